@@ hdl/shac_pkg.sv @@
// ----------------------------------------------------------------------------
// shac_pkg: shared types and constants of the hazard alarm controller
// Field widths, register codes and reset values, timestamp constants and the
// structs passed between the configuration, timing and evaluation blocks.
// ----------------------------------------------------------------------------
package shac_pkg;

    localparam int GAS_W      = 10;
    localparam int TEMP_W     = 16;
    localparam int ACC_W      = 16;
    localparam int VIB_W      = 17;
    localparam int TIME_W     = 32;
    localparam int MASK_W     = 4;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAS_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIB_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd3;

    // register reset values
    localparam logic [GAS_W-1:0]         RST_GAS_THR  = 10'd150;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_THR = 16'sd350;
    localparam logic [VIB_W-1:0]         RST_VIB_THR  = 17'd15000;
    localparam logic [TIME_W-1:0]        RST_INTERVAL = 32'd60000;

    localparam logic signed [VIB_W-1:0] GRAVITY_COUNT = 17'sd16384;

    // timestamp phase: now_ms mod 10000 covers every blink and beep period
    localparam int PHASE_W = 14;
    localparam logic [PHASE_W-1:0] TEMP_BEEP_UNIT_MS = 14'd1000;
    localparam logic [PHASE_W-1:0] VIB_PERIOD_MS     = 14'd5000;
    localparam logic [PHASE_W-1:0] VIB_BEEP1_END     = 14'd200;
    localparam logic [PHASE_W-1:0] VIB_BEEP2_START   = 14'd450;
    localparam logic [PHASE_W-1:0] VIB_BEEP2_END     = 14'd650;

    // (now >> 4) / 625 by reciprocal, one low correction step afterwards
    localparam int PROD_W      = 57;
    localparam int RECIP_SHIFT = 38;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int NIB_W       = TIME_W - 4;
    localparam int REM_W       = 11;
    localparam logic [28:0]      RECIP_625 = 29'd439804651;
    localparam logic [REM_W-1:0] DIV_625   = 11'd625;

    // phase / 200 = (phase >> 3) / 25, phase / 500 = (phase >> 2) / 125
    localparam int P200_W      = 22;
    localparam int P200_SHIFT  = 15;
    localparam int P500_W      = 26;
    localparam int P500_SHIFT  = 20;
    localparam logic [10:0] RECIP_25  = 11'd1311;
    localparam logic [13:0] RECIP_125 = 14'd8389;

    // hazard mask bits
    localparam int BIT_FIRE  = 0;
    localparam int BIT_SMOKE = 1;
    localparam int BIT_TEMP  = 2;
    localparam int BIT_VIB   = 3;

    // message codes
    localparam logic [CODE_W-1:0] MSG_FIRE_SMOKE = 3'd0;
    localparam logic [CODE_W-1:0] MSG_FIRE       = 3'd1;
    localparam logic [CODE_W-1:0] MSG_SMOKE      = 3'd2;
    localparam logic [CODE_W-1:0] MSG_TEMP       = 3'd3;
    localparam logic [CODE_W-1:0] MSG_VIB        = 3'd4;
    localparam logic [CODE_W-1:0] MSG_GENERIC    = 3'd5;

    typedef struct packed {
        logic [GAS_W-1:0]         gas_thr;
        logic signed [TEMP_W-1:0] temp_thr;
        logic [VIB_W-1:0]         vib_thr;
        logic [TIME_W-1:0]        interval;
    } t_cfg;

    typedef struct packed {
        logic [GAS_W-1:0]         gas;
        logic                     flame;
        logic                     temp_valid;
        logic signed [TEMP_W-1:0] temp;
        logic [TIME_W-1:0]        now;
    } t_sample;

    typedef struct packed {
        logic fast;
        logic slow;
        logic temp_beep;
        logic vib_beep;
    } t_phase;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              fan;
        logic              pump;
        logic              green;
        logic              yellow;
        logic              red;
        logic              buzzer;
        logic              alert;
        logic [CODE_W-1:0] code;
    } t_result;

endpackage

@@ hdl/shac_cfg.sv @@
// ----------------------------------------------------------------------------
// shac_cfg: configuration register file
// Decodes register writes, masks each value to its width, holds thresholds.
// ----------------------------------------------------------------------------
module shac_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [shac_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [shac_pkg::CFG_DATA_W-1:0] i_wr_data,
    output shac_pkg::t_cfg                   o_cfg
);
    import shac_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                REG_GAS_THR:  n_cfg.gas_thr  = i_wr_data[GAS_W-1:0];
                REG_TEMP_THR: n_cfg.temp_thr = i_wr_data[TEMP_W-1:0];
                REG_VIB_THR:  n_cfg.vib_thr  = i_wr_data[VIB_W-1:0];
                REG_INTERVAL: n_cfg.interval = i_wr_data[TIME_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gas_thr  <= RST_GAS_THR;
            r_cfg.temp_thr <= RST_TEMP_THR;
            r_cfg.vib_thr  <= RST_VIB_THR;
            r_cfg.interval <= RST_INTERVAL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/shac_phase.sv @@
// ----------------------------------------------------------------------------
// shac_phase: timestamp phase pipeline
// Three stages: now mod 10000 by reciprocal multiply, then blink and beep
// phases from that remainder.
// ----------------------------------------------------------------------------
module shac_phase (
    input  logic                         i_clk,
    input  shac_pkg::t_pipe_en           i_en,
    input  logic [shac_pkg::TIME_W-1:0]  i_now,
    output shac_pkg::t_phase             o_phase
);
    import shac_pkg::*;

    logic [TIME_W-1:0]  r_now2;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  n_prod;
    logic [QUOT_W-1:0]  quot;
    logic [NIB_W-1:0]   rem_full;
    logic [REM_W-1:0]   rem_raw;
    logic [REM_W-1:0]   rem_fix;
    logic [PHASE_W-1:0] r_rem;
    logic [PHASE_W-1:0] n_rem;
    logic [P200_W-1:0]  p200;
    logic [P500_W-1:0]  p500;
    logic [PHASE_W-1:0] slot;
    t_phase             r_phase;
    t_phase             n_phase;

    // stage 2: reciprocal product
    assign n_prod = PROD_W'(i_now[TIME_W-1:4]) * PROD_W'(RECIP_625);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_now2 <= i_now;
            r_prod <= n_prod;
        end
    end

    // stage 3: remainder and correction
    assign quot     = r_prod[PROD_W-1:RECIP_SHIFT];
    assign rem_full = r_now2[TIME_W-1:4] - (NIB_W'(quot) * NIB_W'(DIV_625));
    assign rem_raw  = rem_full[REM_W-1:0];
    assign rem_fix  = (rem_raw >= DIV_625) ? (rem_raw - DIV_625) : rem_raw;
    assign n_rem    = {rem_fix[REM_W-2:0], r_now2[3:0]};

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_rem <= n_rem;
        end
    end

    // stage 4: phases
    assign p200 = P200_W'(r_rem[PHASE_W-1:3]) * P200_W'(RECIP_25);
    assign p500 = P500_W'(r_rem[PHASE_W-1:2]) * P500_W'(RECIP_125);
    assign slot = (r_rem >= VIB_PERIOD_MS) ? (r_rem - VIB_PERIOD_MS) : r_rem;

    always_comb begin
        n_phase.fast      = p200[P200_SHIFT];
        n_phase.slow      = p500[P500_SHIFT];
        n_phase.temp_beep = r_rem < TEMP_BEEP_UNIT_MS;
        n_phase.vib_beep  = (slot < VIB_BEEP1_END) ||
                            ((slot > VIB_BEEP2_START) && (slot < VIB_BEEP2_END));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_phase <= n_phase;
        end
    end

    assign o_phase = r_phase;

endmodule

@@ hdl/shac_eval.sv @@
// ----------------------------------------------------------------------------
// shac_eval: hazard evaluation and alert state
// Forms the hazard mask, drives relays, lamps, buzzer and message code, and
// keeps the held temperature, previous mask and last alert time.
// ----------------------------------------------------------------------------
module shac_eval (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  shac_pkg::t_sample           i_sample,
    input  logic [shac_pkg::VIB_W-1:0]  i_vib,
    input  shac_pkg::t_phase            i_phase,
    input  shac_pkg::t_cfg              i_cfg,
    output shac_pkg::t_result           o_result
);
    import shac_pkg::*;

    logic signed [TEMP_W-1:0] r_held;
    logic [MASK_W-1:0]        r_prev_mask;
    logic [TIME_W-1:0]        r_last_alert;
    logic signed [TEMP_W-1:0] temp_cur;
    logic signed [TEMP_W-1:0] temp_thr;
    logic [TIME_W-1:0]        since;
    logic [MASK_W-1:0]        mask;
    logic                     alert;
    t_result                  res;

    assign temp_cur = i_sample.temp_valid ? i_sample.temp : r_held;
    assign temp_thr = i_cfg.temp_thr;
    assign since    = i_sample.now - r_last_alert;

    always_comb begin
        mask[BIT_FIRE]  = i_sample.flame;
        mask[BIT_SMOKE] = i_sample.gas > i_cfg.gas_thr;
        mask[BIT_TEMP]  = temp_cur > temp_thr;
        mask[BIT_VIB]   = i_vib > i_cfg.vib_thr;
    end

    assign alert = (mask != '0) &&
                   ((mask != r_prev_mask) || (since >= i_cfg.interval));

    always_comb begin
        res        = '0;
        res.mask   = mask;
        res.fan    = mask[BIT_SMOKE];
        res.pump   = mask[BIT_FIRE];
        res.alert  = alert;

        priority if (mask == '0) begin
            res.green = 1'b1;
        end else if (mask[BIT_FIRE] || mask[BIT_SMOKE]) begin
            res.red    = i_phase.fast;
            res.yellow = mask[BIT_TEMP] || mask[BIT_VIB];
            res.buzzer = 1'b1;
        end else begin
            res.yellow = i_phase.slow;
            res.buzzer = mask[BIT_TEMP] ? i_phase.temp_beep : i_phase.vib_beep;
        end

        priority if (mask[BIT_FIRE] && mask[BIT_SMOKE]) begin
            res.code = MSG_FIRE_SMOKE;
        end else if (mask[BIT_FIRE]) begin
            res.code = MSG_FIRE;
        end else if (mask[BIT_SMOKE]) begin
            res.code = MSG_SMOKE;
        end else if (mask[BIT_TEMP]) begin
            res.code = MSG_TEMP;
        end else if (mask[BIT_VIB]) begin
            res.code = MSG_VIB;
        end else begin
            res.code = MSG_GENERIC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_prev_mask  <= '0;
            r_last_alert <= '0;
        end else if (i_load) begin
            r_held      <= temp_cur;
            r_prev_mask <= mask;
            if (alert) begin
                r_last_alert <= i_sample.now;
            end
        end
    end

    assign o_result = res;

endmodule

@@ hdl/sensor_hazard_alarm_controller.sv @@
// ----------------------------------------------------------------------------
// sensor_hazard_alarm_controller: one beat per cycle sustained unless the
// output stalls. Stages: input, timestamp product, mod 10000, phases,
// evaluation into the output register. Synchronous active-low reset clears the
// pipeline, thresholds to defaults and the alert state.
// ----------------------------------------------------------------------------
module sensor_hazard_alarm_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [shac_pkg::GAS_W-1:0]          i_gas_level,
    input  logic                                i_flame_detected,
    input  logic                                i_temp_valid,
    input  logic signed [shac_pkg::TEMP_W-1:0]  i_temperature_x10,
    input  logic signed [shac_pkg::ACC_W-1:0]   i_accel_x,
    input  logic signed [shac_pkg::ACC_W-1:0]   i_accel_y,
    input  logic signed [shac_pkg::ACC_W-1:0]   i_accel_z,
    input  logic [shac_pkg::TIME_W-1:0]         i_now_ms,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [shac_pkg::MASK_W-1:0]         o_hazard_mask,
    output logic                                o_fan_on,
    output logic                                o_pump_on,
    output logic                                o_green_lamp,
    output logic                                o_yellow_lamp,
    output logic                                o_red_lamp,
    output logic                                o_buzzer_on,
    output logic                                o_alert_request,
    output logic [shac_pkg::CODE_W-1:0]         o_message_code,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [shac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [shac_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import shac_pkg::*;

    logic [5:1]               r_vld;
    logic [5:1]               rdy;
    t_sample                  r_s1;
    t_sample                  r_s2;
    t_sample                  r_s3;
    t_sample                  r_s4;
    t_sample                  n_s1;
    logic signed [ACC_W-1:0]  r_ax;
    logic signed [ACC_W-1:0]  r_ay;
    logic signed [ACC_W-1:0]  r_az;
    logic signed [VIB_W-1:0]  ax_w;
    logic signed [VIB_W-1:0]  ay_w;
    logic signed [VIB_W-1:0]  az_w;
    logic [VIB_W-1:0]         ax_m;
    logic [VIB_W-1:0]         ay_m;
    logic [VIB_W-1:0]         az_m;
    logic [VIB_W-1:0]         n_vib;
    logic [VIB_W-1:0]         r_vib2;
    logic [VIB_W-1:0]         r_vib3;
    logic [VIB_W-1:0]         r_vib4;
    t_cfg                     cfg;
    t_pipe_en                 pipe_en;
    t_phase                   phase;
    t_result                  res;
    t_result                  r_res;

    // pipeline flow control: a stage loads when empty or when it drains
    assign rdy[5] = !r_vld[5] || !i_out_stall;
    assign rdy[4] = !r_vld[4] || rdy[5];
    assign rdy[3] = !r_vld[3] || rdy[4];
    assign rdy[2] = !r_vld[2] || rdy[3];
    assign rdy[1] = !r_vld[1] || rdy[2];

    assign o_in_stall  = !rdy[1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= i_in_valid;
            end
            if (rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
            if (rdy[3]) begin
                r_vld[3] <= r_vld[2];
            end
            if (rdy[4]) begin
                r_vld[4] <= r_vld[3];
            end
            if (rdy[5]) begin
                r_vld[5] <= r_vld[4];
            end
        end
    end

    always_comb begin
        n_s1.gas        = i_gas_level;
        n_s1.flame      = i_flame_detected;
        n_s1.temp_valid = i_temp_valid;
        n_s1.temp       = i_temperature_x10;
        n_s1.now        = i_now_ms;
    end

    // vibration metric |x| + |y| + |z - 1 g|
    assign ax_w  = VIB_W'(r_ax);
    assign ay_w  = VIB_W'(r_ay);
    assign az_w  = VIB_W'(r_az) - GRAVITY_COUNT;
    assign ax_m  = ax_w[VIB_W-1] ? VIB_W'(-ax_w) : VIB_W'(ax_w);
    assign ay_m  = ay_w[VIB_W-1] ? VIB_W'(-ay_w) : VIB_W'(ay_w);
    assign az_m  = az_w[VIB_W-1] ? VIB_W'(-az_w) : VIB_W'(az_w);
    assign n_vib = ax_m + ay_m + az_m;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1 <= n_s1;
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
        end
        if (rdy[2]) begin
            r_s2   <= r_s1;
            r_vib2 <= n_vib;
        end
        if (rdy[3]) begin
            r_s3   <= r_s2;
            r_vib3 <= r_vib2;
        end
        if (rdy[4]) begin
            r_s4   <= r_s3;
            r_vib4 <= r_vib3;
        end
        if (rdy[5]) begin
            r_res <= res;
        end
    end

    assign pipe_en.s2 = rdy[2];
    assign pipe_en.s3 = rdy[3];
    assign pipe_en.s4 = rdy[4];

    shac_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    shac_phase u_phase (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_now   (r_s1.now),
        .o_phase (phase)
    );

    shac_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (rdy[5] && r_vld[4]),
        .i_sample (r_s4),
        .i_vib    (r_vib4),
        .i_phase  (phase),
        .i_cfg    (cfg),
        .o_result (res)
    );

    assign o_out_valid     = r_vld[5];
    assign o_hazard_mask   = r_res.mask;
    assign o_fan_on        = r_res.fan;
    assign o_pump_on       = r_res.pump;
    assign o_green_lamp    = r_res.green;
    assign o_yellow_lamp   = r_res.yellow;
    assign o_red_lamp      = r_res.red;
    assign o_buzzer_on     = r_res.buzzer;
    assign o_alert_request = r_res.alert;
    assign o_message_code  = r_res.code;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ((r_vld == '1) && i_out_stall))
        else $error("input stalled while the pipeline has room");

    a_green_no_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_green_lamp == (o_hazard_mask == '0)))
        else $error("green lamp disagrees with hazard mask");

    a_alert_needs_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alert_request) |-> (o_hazard_mask != '0))
        else $error("alert raised without a hazard");

    a_generic_when_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_hazard_mask == '0)) |->
            ((o_message_code == MSG_GENERIC) && !o_buzzer_on && !o_red_lamp))
        else $error("outputs active without a hazard");

endmodule

@@ tb/sensor_hazard_alarm_controller_test.sv @@
// ----------------------------------------------------------------------------
// sensor_hazard_alarm_controller_test: self-checking bench for the alarm block
// Drives evaluation samples through the valid/stall input channel, predicts
// mask, relays, lamps, buzzer, alert and message code per sample, and compares
// every output beat in order. Covers hazard classes, blink and beep windows,
// alert repeat timing with wrap, register extremes, backpressure and random
// traffic under changing idle patterns.
// ----------------------------------------------------------------------------
module sensor_hazard_alarm_controller_test;
    import shac_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int DRAIN_CYCLES    = 12;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 212;
    localparam int FAST_BLINK_MS   = 200;
    localparam int SLOW_BLINK_MS   = 500;
    localparam int TEMP_BEEP_SLOTS = 10;

    typedef struct packed {
        logic [GAS_W-1:0]         gas;
        logic                     flame;
        logic                     temp_valid;
        logic signed [TEMP_W-1:0] temp;
        logic signed [ACC_W-1:0]  ax;
        logic signed [ACC_W-1:0]  ay;
        logic signed [ACC_W-1:0]  az;
        logic [TIME_W-1:0]        now;
    } t_reading;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic                         i_clk             = 1'b0;
    logic                         i_rst_n           = 1'b0;
    logic                         i_in_valid        = 1'b0;
    logic                         o_in_stall;
    logic [GAS_W-1:0]             i_gas_level       = '0;
    logic                         i_flame_detected  = 1'b0;
    logic                         i_temp_valid      = 1'b0;
    logic signed [TEMP_W-1:0]     i_temperature_x10 = '0;
    logic signed [ACC_W-1:0]      i_accel_x         = '0;
    logic signed [ACC_W-1:0]      i_accel_y         = '0;
    logic signed [ACC_W-1:0]      i_accel_z         = '0;
    logic [TIME_W-1:0]            i_now_ms          = '0;
    logic                         o_out_valid;
    logic                         i_out_stall       = 1'b0;
    logic [MASK_W-1:0]            o_hazard_mask;
    logic                         o_fan_on;
    logic                         o_pump_on;
    logic                         o_green_lamp;
    logic                         o_yellow_lamp;
    logic                         o_red_lamp;
    logic                         o_buzzer_on;
    logic                         o_alert_request;
    logic [CODE_W-1:0]            o_message_code;
    logic                         i_cfg_valid       = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index       = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data        = '0;

    // predictor copy of the registers and alarm state
    logic [GAS_W-1:0]             gas_limit     = RST_GAS_THR;
    logic signed [TEMP_W-1:0]     temp_limit    = RST_TEMP_THR;
    logic [VIB_W-1:0]             vib_limit     = RST_VIB_THR;
    logic [TIME_W-1:0]            repeat_ms     = RST_INTERVAL;
    logic signed [TEMP_W-1:0]     held_temp     = '0;
    logic [MASK_W-1:0]            last_mask     = '0;
    logic [TIME_W-1:0]            last_alert_at = '0;

    t_result          expected_alarms[$];
    t_reg_write       reg_batch[$];
    t_result          alarm_want;
    int               mismatches    = 0;
    int               snd_idle_pct  = 35;
    int               rcv_idle_pct  = 59;
    int               hold_off_left = 0;
    int               quiet_cycles  = 0;
    logic [TIME_W-1:0] clock_ms     = '0;

    sensor_hazard_alarm_controller u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_gas_level       (i_gas_level),
        .i_flame_detected  (i_flame_detected),
        .i_temp_valid      (i_temp_valid),
        .i_temperature_x10 (i_temperature_x10),
        .i_accel_x         (i_accel_x),
        .i_accel_y         (i_accel_y),
        .i_accel_z         (i_accel_z),
        .i_now_ms          (i_now_ms),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_hazard_mask     (o_hazard_mask),
        .o_fan_on          (o_fan_on),
        .o_pump_on         (o_pump_on),
        .o_green_lamp      (o_green_lamp),
        .o_yellow_lamp     (o_yellow_lamp),
        .o_red_lamp        (o_red_lamp),
        .o_buzzer_on       (o_buzzer_on),
        .o_alert_request   (o_alert_request),
        .o_message_code    (o_message_code),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_result predict_alarm(input t_reading r);
        t_result           res;
        int                vib;
        logic [TIME_W-1:0] slot;
        logic [TIME_W-1:0] since;
        logic              fast;
        logic              slow;
        res = '0;
        if (r.temp_valid) held_temp = r.temp;
        vib = magnitude(int'(r.ax)) + magnitude(int'(r.ay)) +
              magnitude(int'(r.az) - int'(GRAVITY_COUNT));
        res.mask[BIT_FIRE]  = r.flame;
        res.mask[BIT_SMOKE] = r.gas > gas_limit;
        res.mask[BIT_TEMP]  = held_temp > temp_limit;
        res.mask[BIT_VIB]   = vib > int'(vib_limit);
        fast = ((r.now / FAST_BLINK_MS) % 2) == 1;
        slow = ((r.now / SLOW_BLINK_MS) % 2) == 1;
        slot = r.now % VIB_PERIOD_MS;
        res.fan  = res.mask[BIT_SMOKE];
        res.pump = res.mask[BIT_FIRE];
        if (res.mask == '0) begin
            res.green = 1'b1;
        end else if (res.mask[BIT_FIRE] || res.mask[BIT_SMOKE]) begin
            res.red    = fast;
            res.yellow = res.mask[BIT_TEMP] || res.mask[BIT_VIB];
            res.buzzer = 1'b1;
        end else begin
            res.yellow = slow;
            if (res.mask[BIT_TEMP]) begin
                res.buzzer = ((r.now / TEMP_BEEP_UNIT_MS) % TEMP_BEEP_SLOTS) == 0;
            end else begin
                res.buzzer = (slot < VIB_BEEP1_END) ||
                             (slot > VIB_BEEP2_START && slot < VIB_BEEP2_END);
            end
        end
        if (res.mask[BIT_FIRE] && res.mask[BIT_SMOKE]) res.code = MSG_FIRE_SMOKE;
        else if (res.mask[BIT_FIRE])                   res.code = MSG_FIRE;
        else if (res.mask[BIT_SMOKE])                  res.code = MSG_SMOKE;
        else if (res.mask[BIT_TEMP])                   res.code = MSG_TEMP;
        else if (res.mask[BIT_VIB])                    res.code = MSG_VIB;
        else                                           res.code = MSG_GENERIC;
        since = r.now - last_alert_at;
        if (res.mask != '0 && (res.mask != last_mask || since >= repeat_ms)) begin
            res.alert     = 1'b1;
            last_alert_at = r.now;
        end
        last_mask = res.mask;
        return res;
    endfunction

    function automatic t_reading reading(input int gas, input bit flame, input bit tvalid,
                                         input int temp, input int ax, input int ay,
                                         input int az, input logic [TIME_W-1:0] now);
        t_reading r;
        r.gas        = GAS_W'(gas);
        r.flame      = flame;
        r.temp_valid = tvalid;
        r.temp       = TEMP_W'(temp);
        r.ax         = ACC_W'(ax);
        r.ay         = ACC_W'(ay);
        r.az         = ACC_W'(az);
        r.now        = now;
        return r;
    endfunction

    function automatic t_reading draw_reading();
        t_reading r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 80)      clock_ms = clock_ms + $urandom_range(1500);
        else if (pick < 95) clock_ms = clock_ms + $urandom_range(100000);
        else                clock_ms = $urandom();
        r.now   = clock_ms;
        r.flame = $urandom_range(3) == 0;
        if ($urandom_range(1)) r.gas = GAS_W'(int'(gas_limit) + int'($urandom_range(16)) - 8);
        else                   r.gas = GAS_W'($urandom());
        r.temp_valid = $urandom_range(1) == 1;
        if ($urandom_range(1))
            r.temp = TEMP_W'(int'(temp_limit) + int'($urandom_range(40)) - 20);
        else
            r.temp = TEMP_W'($urandom());
        if ($urandom_range(9) < 7) begin
            r.ax = ACC_W'(int'($urandom_range(16000)) - 8000);
            r.ay = ACC_W'(int'($urandom_range(16000)) - 8000);
            r.az = ACC_W'(int'(GRAVITY_COUNT) + int'($urandom_range(16000)) - 8000);
        end else begin
            r.ax = ACC_W'($urandom());
            r.ay = ACC_W'($urandom());
            r.az = ACC_W'($urandom());
        end
        return r;
    endfunction

    task automatic send_reading(input t_reading r);
        if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < snd_idle_pct) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_gas_level       <= r.gas;
        i_flame_detected  <= r.flame;
        i_temp_valid      <= r.temp_valid;
        i_temperature_x10 <= r.temp;
        i_accel_x         <= r.ax;
        i_accel_y         <= r.ay;
        i_accel_z         <= r.az;
        i_now_ms          <= r.now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_alarms.push_back(predict_alarm(r));
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_alarms.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_registers();
        drain_pipeline();
        foreach (reg_batch[k]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_batch[k].idx;
            i_cfg_data  <= reg_batch[k].data;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (reg_batch[k].idx)
                REG_GAS_THR:  gas_limit  = reg_batch[k].data[GAS_W-1:0];
                REG_TEMP_THR: temp_limit = reg_batch[k].data[TEMP_W-1:0];
                REG_VIB_THR:  vib_limit  = reg_batch[k].data[VIB_W-1:0];
                REG_INTERVAL: repeat_ms  = reg_batch[k].data;
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
        reg_batch.delete();
    endtask

    task automatic configure(input logic [31:0] gas, input logic [31:0] temp,
                             input logic [31:0] vib, input logic [31:0] interval);
        reg_batch.push_back(t_reg_write'{REG_GAS_THR, gas});
        reg_batch.push_back(t_reg_write'{REG_TEMP_THR, temp});
        reg_batch.push_back(t_reg_write'{REG_VIB_THR, vib});
        reg_batch.push_back(t_reg_write'{REG_INTERVAL, interval});
        write_registers();
    endtask

    task automatic test_hazard_classes();
        send_reading(reading(0,    0, 0, 0,      0,      0,      16384,  0));
        send_reading(reading(150,  0, 0, 0,      0,      0,      16384,  100));
        send_reading(reading(151,  0, 0, 0,      0,      0,      16384,  200));
        send_reading(reading(1023, 1, 0, 0,      0,      0,      16384,  400));
        send_reading(reading(0,    1, 0, 0,      0,      0,      16384,  600));
        send_reading(reading(0,    0, 1, 351,    0,      0,      16384,  1000));
        send_reading(reading(0,    0, 0, -32768, 0,      0,      16384,  1500));
        send_reading(reading(0,    0, 1, 350,    -32768, -32768, -32768, 2000));
        send_reading(reading(1023, 1, 1, 32767,  32767,  32767,  32767,  2200));
        send_reading(reading(0,    0, 1, -32768, 0,      0,      16384,  2400));
    endtask

    task automatic test_blink_and_beep_windows();
        send_reading(reading(0, 0, 0, 0,   20000, 0, 16384, 0));
        send_reading(reading(0, 0, 0, 0,   20000, 0, 16384, 199));
        send_reading(reading(0, 0, 0, 0,   20000, 0, 16384, 200));
        send_reading(reading(0, 0, 0, 0,   20000, 0, 16384, 450));
        send_reading(reading(0, 0, 0, 0,   20000, 0, 16384, 451));
        send_reading(reading(0, 0, 0, 0,   20000, 0, 16384, 649));
        send_reading(reading(0, 0, 0, 0,   20000, 0, 16384, 650));
        send_reading(reading(0, 0, 0, 0,   20000, 0, 16384, 5100));
        send_reading(reading(0, 0, 1, 400, 0,     0, 16384, 10000));
        send_reading(reading(0, 0, 1, 400, 0,     0, 16384, 10999));
        send_reading(reading(0, 0, 1, 400, 0,     0, 16384, 11000));
        send_reading(reading(0, 0, 1, 400, 0,     0, 16384, 32'hFFFF_FFFF));
    endtask

    task automatic test_alert_repeat();
        send_reading(reading(0, 0, 1, 0, 20000, 0, 16384, 100));
        send_reading(reading(0, 0, 0, 0, 20000, 0, 16384, 60099));
        send_reading(reading(0, 0, 0, 0, 20000, 0, 16384, 60100));
        send_reading(reading(0, 0, 0, 0, 20000, 0, 16384, 32'hFFFF_FFF0));
        send_reading(reading(0, 0, 0, 0, 20000, 0, 16384, 32'h0000_EA50));
        send_reading(reading(0, 0, 0, 0, 20000, 0, 16384, 32'h0000_EA51));
        configure(32'(RST_GAS_THR), 32'(RST_TEMP_THR), 32'(RST_VIB_THR), 32'd0);
        send_reading(reading(0, 0, 0, 0, 20000, 0, 16384, 70000));
        send_reading(reading(0, 0, 0, 0, 20000, 0, 16384, 70000));
        configure(32'(RST_GAS_THR), 32'(RST_TEMP_THR), 32'(RST_VIB_THR), 32'hFFFF_FFFF);
        send_reading(reading(0, 0, 0, 0, 20000, 0, 16384, 80000));
        send_reading(reading(0, 0, 0, 0, 0,     0, 16384, 80001));
        send_reading(reading(0, 0, 0, 0, 20000, 0, 16384, 80002));
    endtask

    task automatic test_register_limits();
        for (int k = int'(REG_INTERVAL) + 1; k < (1 << CFG_IDX_W); k++)
            reg_batch.push_back(t_reg_write'{CFG_IDX_W'(k), $urandom()});
        configure(32'hFFFF_FC00, 32'hFFFF_8000, 32'hFFFE_0000, 32'd0);
        send_reading(reading(0,    0, 1, -32768, 0,      0,      16384,  300));
        send_reading(reading(1,    0, 1, -32767, 1,      0,      16384,  301));
        configure(32'h0000_03FF, 32'h0000_7FFF, 32'h0001_FFFF, 32'hFFFF_FFFF);
        send_reading(reading(1023, 0, 1, 32767,  -32768, -32768, -32768, 302));
        send_reading(reading(1023, 1, 0, 0,      -32768, -32768, -32768, 303));
    endtask

    task automatic test_backpressure();
        configure(32'(RST_GAS_THR), 32'(RST_TEMP_THR), 32'(RST_VIB_THR), RST_INTERVAL);
        hold_off_left <= HOLD_OFF_CYCLES;
        repeat (40) send_reading(draw_reading());
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            snd_idle_pct = (phase < 2) ? 35 : (phase < 4) ? 59 : 0;
            rcv_idle_pct = (phase < 2) ? 59 : (phase < 4) ? 35 : 0;
            if (phase == 1)
                configure({22'($urandom()), 10'd0}, {16'($urandom()), 16'h8000},
                          {15'($urandom()), 17'd0}, 32'd0);
            else if (phase == 4)
                configure({22'($urandom()), 10'h3FF}, {16'($urandom()), 16'h7FFF},
                          {15'($urandom()), 17'h1FFFF}, 32'hFFFF_FFFF);
            else
                configure({22'($urandom()), 10'($urandom_range(100, 900))},
                          {16'($urandom()), 16'(int'($urandom_range(700)) - 200)},
                          {15'($urandom()), 17'($urandom_range(5000, 40000))},
                          $urandom_range(3000));
            repeat (PHASE_ITEMS) send_reading(draw_reading());
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_stall   <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end else begin
            i_out_stall <= rcv_idle_pct != 0 && $urandom_range(99) < rcv_idle_pct;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_alarms.size() == 0) begin
                $display("%0t: alarm beat expected none, got mask %0h code %0h",
                         $time, o_hazard_mask, o_message_code);
                mismatches++;
            end else begin
                alarm_want = expected_alarms.pop_front();
                check_field("hazard_mask",   alarm_want.mask,   o_hazard_mask);
                check_field("fan_on",        alarm_want.fan,    o_fan_on);
                check_field("pump_on",       alarm_want.pump,   o_pump_on);
                check_field("green_lamp",    alarm_want.green,  o_green_lamp);
                check_field("yellow_lamp",   alarm_want.yellow, o_yellow_lamp);
                check_field("red_lamp",      alarm_want.red,    o_red_lamp);
                check_field("buzzer_on",     alarm_want.buzzer, o_buzzer_on);
                check_field("alert_request", alarm_want.alert,  o_alert_request);
                check_field("message_code",  alarm_want.code,   o_message_code);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_hazard_classes();
        test_blink_and_beep_windows();
        test_alert_repeat();
        test_register_limits();
        test_backpressure();
        test_random_traffic();
        drain_pipeline();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
